[hdl/rbsi_pkg.sv]
// Shared constants, types and helper functions for the ray/box slab intersection core.
package rbsi_pkg;

    localparam int COORD_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int IN_DATA_W  = 192;
    localparam int OUT_DATA_W = 72;
    localparam int AXES       = 3;

    localparam int DIV_STEPS    = 33;
    localparam int DIV_PER_STG  = 4;
    localparam int DIV_STG      = (DIV_STEPS + DIV_PER_STG - 1) / DIV_PER_STG;

    localparam int ST_PROD = 0;
    localparam int ST_SUM  = 1;
    localparam int ST_DIV0 = 2;
    localparam int ST_REC  = ST_DIV0 + DIV_STG;
    localparam int ST_MUL  = ST_REC + 1;
    localparam int ST_SLAB = ST_MUL + 1;
    localparam int ST_OUT  = ST_SLAB + 1;
    localparam int NSTG    = ST_OUT + 1;

    localparam logic [CFG_IDX_W-1:0] REG_XFORM0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_XFORM1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_XFORM2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_XY   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_Z    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_XY  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_Z   = 3'd6;

    localparam logic [47:0] XFORM0_RST  = 48'h0000_0000_4000;
    localparam logic [47:0] XFORM1_RST  = 48'h0000_4000_0000;
    localparam logic [47:0] XFORM2_RST  = 48'h4000_0000_0000;
    localparam logic [63:0] HALF_XY_RST = 64'h0001_0000_0001_0000;
    localparam logic [31:0] HALF_Z_RST  = 32'h0001_0000;

    localparam logic signed [31:0] MINUS_ONE = 32'shFFFF_0000;
    localparam logic [30:0]        LIM_MAX   = 31'h7FFF_FFFF;

    typedef struct packed {
        logic [31:0] rem;
        logic [32:0] quo;
    } t_div;

    function automatic t_div div_step(input t_div cur, input logic [31:0] md,
                                      input logic bit_in);
        logic [32:0] t;
        t_div        nxt;
        t = {cur.rem, bit_in};
        if (t >= {1'b0, md}) begin
            t = t - {1'b0, md};
            nxt.quo = {cur.quo[31:0], 1'b1};
        end else begin
            nxt.quo = {cur.quo[31:0], 1'b0};
        end
        nxt.rem = t[31:0];
        return nxt;
    endfunction

    function automatic logic signed [31:0] sat_c(input logic signed [50:0] v);
        logic signed [31:0] r;
        if (v > 51'sh0_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -51'sh0_0000_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

[hdl/ray_box_slab_intersect_core.sv]
// Ray versus transformed axis-aligned box, slab method, Q16.16, fully pipelined.
// Depth: 15 register stages, from the product stage to the output stage.
// Throughput: one item per cycle while the output accepts; the reciprocal divider is the deepest section (9 stages).
// Each stage stalls only when it holds an item and the stage after it cannot move.
// Reset (synchronous, active low) clears all valid bits and loads register defaults.
module ray_box_slab_intersect_core
    import rbsi_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z (32 bits each)
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // hit, t_near[31:0], t_far[31:0], zero pad
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    logic [47:0] r_xform [AXES];
    logic [63:0] r_off_xy;
    logic [31:0] r_off_z;
    logic [63:0] r_half_xy;
    logic [31:0] r_half_z;

    logic [NSTG-1:0] r_v;
    logic [NSTG:0]   w_en;

    logic signed [47:0] r_pd [AXES][AXES];
    logic signed [47:0] r_po [AXES][AXES];
    logic signed [31:0] r_bd [AXES];
    logic signed [31:0] r_bo [AXES];
    t_div               r_dv [DIV_STG][AXES];
    logic [31:0]        r_dv_md [DIV_STG][AXES];
    logic               r_dv_neg [DIV_STG][AXES];
    logic               r_dv_zero [DIV_STG][AXES];
    logic signed [31:0] r_dv_bo [DIV_STG][AXES];
    logic [30:0]        r_m_mag [AXES];
    logic               r_m_neg [AXES];
    logic signed [31:0] r_m_bo [AXES];
    logic [62:0]        r_pn [AXES];
    logic [62:0]        r_pk [AXES];
    logic               r_n_neg [AXES];
    logic signed [31:0] r_tn, r_tf;
    logic               r_hit;
    logic signed [31:0] r_out_tn, r_out_tf;

    logic signed [47:0] n_pd [AXES][AXES];
    logic signed [47:0] n_po [AXES][AXES];
    logic signed [31:0] n_bd [AXES];
    logic signed [31:0] n_bo [AXES];
    t_div               n_dv [DIV_STG][AXES];
    logic [30:0]        n_m_mag [AXES];
    logic               n_m_neg [AXES];
    logic [62:0]        n_pn [AXES];
    logic [62:0]        n_pk [AXES];
    logic               n_n_neg [AXES];
    logic signed [31:0] n_tn, n_tf;
    logic               n_hit;
    logic signed [31:0] n_out_tn, n_out_tf;

    logic signed [31:0] w_off [AXES];
    logic [31:0]        w_half [AXES];

    assign w_off[0]  = r_off_xy[31:0];
    assign w_off[1]  = r_off_xy[63:32];
    assign w_off[2]  = r_off_z;
    assign w_half[0] = r_half_xy[31:0];
    assign w_half[1] = r_half_xy[63:32];
    assign w_half[2] = r_half_z;

    // stage handshake chain
    always_comb begin
        w_en[NSTG] = i_m_axis_tready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign o_s_axis_tready = w_en[0];
    assign o_m_axis_tvalid = r_v[ST_OUT];
    assign o_m_axis_tdata  = {7'd0, r_out_tf, r_out_tn, r_hit};

    always_comb begin
        logic signed [15:0] c;
        logic signed [31:0] o;
        logic signed [31:0] d;
        logic signed [49:0] sd, so;
        logic [31:0]        md;
        t_div               cur;
        int                 step;
        logic [32:0]        q;
        logic [31:0]        bo_mag;
        logic [46:0]        nm, km;
        logic signed [34:0] nv, kv;
        logic signed [31:0] t1, t2;

        for (int a = 0; a < AXES; a++) begin
            for (int j = 0; j < AXES; j++) begin
                c = r_xform[a][16*j +: 16];
                o = i_s_axis_tdata[32*j +: 32];
                d = i_s_axis_tdata[96 + 32*j +: 32];
                n_pd[a][j] = c * d;
                n_po[a][j] = c * o;
            end
        end

        for (int a = 0; a < AXES; a++) begin
            sd = 50'(r_pd[a][0]) + 50'(r_pd[a][1]) + 50'(r_pd[a][2]);
            so = 50'(r_po[a][0]) + 50'(r_po[a][1]) + 50'(r_po[a][2]);
            n_bd[a] = sat_c(51'(sd >>> 14));
            n_bo[a] = sat_c(51'(so >>> 14) + 51'(w_off[a]));
        end

        for (int s = 0; s < DIV_STG; s++) begin
            for (int a = 0; a < AXES; a++) begin
                if (s == 0) begin
                    cur = '0;
                    md  = r_bd[a][31] ? 32'(-r_bd[a]) : 32'(r_bd[a]);
                end else begin
                    cur = r_dv[s-1][a];
                    md  = r_dv_md[s-1][a];
                end
                for (int i = 0; i < DIV_PER_STG; i++) begin
                    step = s * DIV_PER_STG + i;
                    if (step < DIV_STEPS) begin
                        cur = div_step(cur, md, step == 0);
                    end
                end
                n_dv[s][a] = cur;
            end
        end

        for (int a = 0; a < AXES; a++) begin
            q = r_dv[DIV_STG-1][a].quo;
            if (r_dv_zero[DIV_STG-1][a]) begin
                n_m_mag[a] = LIM_MAX;
                n_m_neg[a] = 1'b0;
            end else begin
                n_m_mag[a] = (q > {2'b00, LIM_MAX}) ? LIM_MAX : q[30:0];
                n_m_neg[a] = r_dv_neg[DIV_STG-1][a];
            end
        end

        for (int a = 0; a < AXES; a++) begin
            bo_mag     = r_m_bo[a][31] ? 32'(-r_m_bo[a]) : 32'(r_m_bo[a]);
            n_pn[a]    = 63'(r_m_mag[a]) * 63'(bo_mag);
            n_pk[a]    = 63'(r_m_mag[a]) * 63'(w_half[a]);
            n_n_neg[a] = r_m_neg[a] ^ r_m_bo[a][31];
        end

        n_tn = '0;
        n_tf = '0;
        for (int a = 0; a < AXES; a++) begin
            nm = r_pn[a][62:16];
            km = r_pk[a][62:16];
            if (r_n_neg[a]) begin
                nv = (nm > 47'h0_8000_0000) ? -35'sh0_8000_0000 : -35'($signed({1'b0, nm}));
            end else begin
                nv = (nm > 47'h0_7FFF_FFFF) ? 35'sh0_7FFF_FFFF : 35'($signed({1'b0, nm}));
            end
            kv = (km > 47'h0_7FFF_FFFF) ? 35'sh0_7FFF_FFFF : 35'($signed({1'b0, km}));
            t1 = sat_c(51'(-nv - kv));
            t2 = sat_c(51'(-nv + kv));
            if (a == 0 || t1 > n_tn) begin
                n_tn = t1;
            end
            if (a == 0 || t2 < n_tf) begin
                n_tf = t2;
            end
        end

        if (r_tn > r_tf || r_tf < 0) begin
            n_hit    = 1'b0;
            n_out_tn = MINUS_ONE;
            n_out_tf = MINUS_ONE;
        end else begin
            n_hit    = 1'b1;
            n_out_tn = r_tn;
            n_out_tf = r_tf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xform[0] <= XFORM0_RST;
            r_xform[1] <= XFORM1_RST;
            r_xform[2] <= XFORM2_RST;
            r_off_xy   <= '0;
            r_off_z    <= '0;
            r_half_xy  <= HALF_XY_RST;
            r_half_z   <= HALF_Z_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_XFORM0:  r_xform[0] <= i_cfg_wdata[47:0];
                REG_XFORM1:  r_xform[1] <= i_cfg_wdata[47:0];
                REG_XFORM2:  r_xform[2] <= i_cfg_wdata[47:0];
                REG_OFF_XY:  r_off_xy   <= i_cfg_wdata;
                REG_OFF_Z:   r_off_z    <= i_cfg_wdata[31:0];
                REG_HALF_XY: r_half_xy  <= i_cfg_wdata;
                REG_HALF_Z:  r_half_z   <= i_cfg_wdata[31:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= (k == 0) ? i_s_axis_tvalid : r_v[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_PROD]) begin
            r_pd <= n_pd;
            r_po <= n_po;
        end
        if (w_en[ST_SUM]) begin
            r_bd <= n_bd;
            r_bo <= n_bo;
        end
        for (int s = 0; s < DIV_STG; s++) begin
            if (w_en[ST_DIV0 + s]) begin
                for (int a = 0; a < AXES; a++) begin
                    r_dv[s][a] <= n_dv[s][a];
                    if (s == 0) begin
                        r_dv_md[s][a]   <= r_bd[a][31] ? 32'(-r_bd[a]) : 32'(r_bd[a]);
                        r_dv_neg[s][a]  <= r_bd[a][31];
                        r_dv_zero[s][a] <= (r_bd[a] == 0);
                        r_dv_bo[s][a]   <= r_bo[a];
                    end else begin
                        r_dv_md[s][a]   <= r_dv_md[s-1][a];
                        r_dv_neg[s][a]  <= r_dv_neg[s-1][a];
                        r_dv_zero[s][a] <= r_dv_zero[s-1][a];
                        r_dv_bo[s][a]   <= r_dv_bo[s-1][a];
                    end
                end
            end
        end
        if (w_en[ST_REC]) begin
            r_m_mag <= n_m_mag;
            r_m_neg <= n_m_neg;
            r_m_bo  <= r_dv_bo[DIV_STG-1];
        end
        if (w_en[ST_MUL]) begin
            r_pn    <= n_pn;
            r_pk    <= n_pk;
            r_n_neg <= n_n_neg;
        end
        if (w_en[ST_SLAB]) begin
            r_tn <= n_tn;
            r_tf <= n_tf;
        end
        if (w_en[ST_OUT]) begin
            r_hit    <= n_hit;
            r_out_tn <= n_out_tn;
            r_out_tf <= n_out_tf;
        end
    end

    a_miss_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tdata[0]) |->
            (o_m_axis_tdata[32:1] == MINUS_ONE && o_m_axis_tdata[64:33] == MINUS_ONE))
        else $error("miss result not -1.0");

    a_hit_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[0]) |->
            ($signed(o_m_axis_tdata[32:1]) <= $signed(o_m_axis_tdata[64:33])
             && !o_m_axis_tdata[64]))
        else $error("hit with bad interval");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (o_m_axis_tvalid && !i_m_axis_tready && (&r_v)))
        else $error("input blocked without a full stalled pipe");

endmodule

[bench/ray_box_slab_intersect_checker.sv]
// Checker for the ray/box slab core: predicts each ray's result and compares it on the output.
`timescale 1ns / 1ps
module ray_box_slab_intersect_checker
    import rbsi_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_s_axis_tvalid,
    input  logic                  i_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    input  logic                  i_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    input  logic [OUT_DATA_W-1:0] i_m_axis_tdata,
    output int                    o_fail_cnt,
    output int                    o_pending,
    output int                    o_rays,
    output int                    o_hits
);

    // packed from the top down, so hit sits in bit 0 as on the bus
    typedef struct packed {
        logic [31:0] t_far;
        logic [31:0] t_near;
        logic        hit;
    } t_slab_hit;

    localparam longint QMAX = 64'sh7FFF_FFFF;
    localparam longint QMIN = -64'sh8000_0000;

    logic [47:0] xform_row [3];
    logic [63:0] off_xy;
    logic [31:0] off_z;
    logic [63:0] half_xy;
    logic [31:0] half_z;

    t_slab_hit expected_hits[$];

    function automatic longint clamp_q(input longint v);
        if (v > QMAX) return QMAX;
        if (v < QMIN) return QMIN;
        return v;
    endfunction

    function automatic t_slab_hit predict_slab(input logic [IN_DATA_W-1:0] ray);
        longint            o, d, off, c, accd, acco, bd, bo, m, n, k, t1, t2, tn, tf;
        longint unsigned   half, q, p;
        t_slab_hit         res;
        tn = 0;
        tf = 0;
        for (int r = 0; r < 3; r++) begin
            accd = 0;
            acco = 0;
            for (int j = 0; j < 3; j++) begin
                c = $signed(xform_row[r][16*j +: 16]);
                o = $signed(ray[32*j +: 32]);
                d = $signed(ray[96 + 32*j +: 32]);
                accd += c * d;
                acco += c * o;
            end
            off  = (r == 0) ? $signed(off_xy[31:0]) : (r == 1) ? $signed(off_xy[63:32])
                                                      : $signed(off_z);
            half = (r == 0) ? half_xy[31:0] : (r == 1) ? half_xy[63:32] : half_z;
            bd = clamp_q(accd >>> 14);
            bo = clamp_q((acco >>> 14) + off);
            if (bd == 0) begin
                m = QMAX;
            end else begin
                q = 64'h1_0000_0000 / longint'(bd < 0 ? -bd : bd);
                if (q > QMAX) q = QMAX;
                m = (bd < 0) ? -longint'(q) : longint'(q);
            end
            p = longint'(m < 0 ? -m : m) * longint'(bo < 0 ? -bo : bo);
            p = p >> 16;
            if ((m < 0) != (bo < 0)) n = -longint'((p > 64'h8000_0000) ? 64'h8000_0000 : p);
            else                     n = longint'((p > QMAX) ? QMAX : p);
            p = longint'(m < 0 ? -m : m) * half;
            p = p >> 16;
            k = longint'((p > QMAX) ? QMAX : p);
            t1 = clamp_q(-n - k);
            t2 = clamp_q(-n + k);
            if (r == 0 || t1 > tn) tn = t1;
            if (r == 0 || t2 < tf) tf = t2;
        end
        if (tn > tf || tf < 0) begin
            res.hit    = 1'b0;
            res.t_near = MINUS_ONE;
            res.t_far  = MINUS_ONE;
        end else begin
            res.hit    = 1'b1;
            res.t_near = tn[31:0];
            res.t_far  = tf[31:0];
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_slab_hit want, got;
        if (!i_rst_n) begin
            xform_row[0] = XFORM0_RST;
            xform_row[1] = XFORM1_RST;
            xform_row[2] = XFORM2_RST;
            off_xy       = '0;
            off_z        = '0;
            half_xy      = HALF_XY_RST;
            half_z       = HALF_Z_RST;
            expected_hits.delete();
            o_fail_cnt   = 0;
            o_rays       = 0;
            o_hits       = 0;
        end else begin
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                expected_hits.push_back(predict_slab(i_s_axis_tdata));
                o_rays++;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_XFORM0:  xform_row[0] = i_cfg_wdata[47:0];
                    REG_XFORM1:  xform_row[1] = i_cfg_wdata[47:0];
                    REG_XFORM2:  xform_row[2] = i_cfg_wdata[47:0];
                    REG_OFF_XY:  off_xy  = i_cfg_wdata;
                    REG_OFF_Z:   off_z   = i_cfg_wdata[31:0];
                    REG_HALF_XY: half_xy = i_cfg_wdata;
                    REG_HALF_Z:  half_z  = i_cfg_wdata[31:0];
                    default: ;
                endcase
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got = i_m_axis_tdata[64:0];
                if (expected_hits.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    o_fail_cnt++;
                end else begin
                    want = expected_hits.pop_front();
                    if (want.hit) o_hits++;
                    if (got.hit !== want.hit) begin
                        $display("%0t: hit expected %b actual %b", $time, want.hit, got.hit);
                        o_fail_cnt++;
                    end
                    if (got.t_near !== want.t_near) begin
                        $display("%0t: t_near expected %h actual %h", $time,
                                 want.t_near, got.t_near);
                        o_fail_cnt++;
                    end
                    if (got.t_far !== want.t_far) begin
                        $display("%0t: t_far expected %h actual %h", $time,
                                 want.t_far, got.t_far);
                        o_fail_cnt++;
                    end
                end
            end
        end
        o_pending = expected_hits.size();
    end

endmodule

[bench/ray_box_slab_intersect_core_test.sv]
// Testbench top for the ray/box slab core: clock, reset, configuration and ray stimulus.
`timescale 1ns / 1ps
module ray_box_slab_intersect_core_test;
    import rbsi_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;

    int fail_cnt, pending, rays, hits;
    int cycles = 0;
    bit no_idle = 1'b0;
    int stall_tag = 0;
    int stall_seen = 0;
    int stall_left = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    ray_box_slab_intersect_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_wdata(i_cfg_wdata),
        .i_s_axis_tvalid(i_s_axis_tvalid), .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata(i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid), .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata(o_m_axis_tdata)
    );

    ray_box_slab_intersect_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_wdata(i_cfg_wdata),
        .i_s_axis_tvalid(i_s_axis_tvalid), .i_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata(i_s_axis_tdata),
        .i_m_axis_tvalid(o_m_axis_tvalid), .i_m_axis_tready(i_m_axis_tready),
        .i_m_axis_tdata(o_m_axis_tdata),
        .o_fail_cnt(fail_cnt), .o_pending(pending), .o_rays(rays), .o_hits(hits)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("ray_box_slab_intersect_core_test NOT OK");
            $finish;
        end
    end

    // receiver: random backpressure, plus long hold-offs on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (stall_tag != stall_seen) begin
            stall_seen      <= stall_tag;
            stall_left      <= 400;
            i_m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left      <= stall_left - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= no_idle || ($urandom_range(99) >= 24);
        end
    end

    function automatic logic [IN_DATA_W-1:0] pack_ray(input logic [31:0] ox, oy, oz,
                                                      dx, dy, dz);
        return {dz, dy, dx, oz, oy, ox};
    endfunction

    function automatic logic [31:0] q_rand(input int span);
        return 32'($signed($urandom_range(2 * span)) - span);
    endfunction

    function automatic logic [IN_DATA_W-1:0] random_ray();
        logic [31:0] p [3];
        logic [31:0] d [3];
        int          kind;
        kind = $urandom_range(9);
        for (int j = 0; j < 3; j++) begin
            case (kind)
                0, 1: begin
                    p[j] = $urandom();
                    d[j] = $urandom();
                end
                2, 3, 4: begin
                    p[j] = q_rand(4 << 16);
                    d[j] = ($urandom_range(7) == 0) ? 32'd0 : q_rand(2 << 16);
                end
                default: begin
                    p[j] = q_rand(6 << 16);
                    d[j] = -p[j] + q_rand(1 << 16);
                    if ($urandom_range(15) == 0) d[j] = 32'd0;
                end
            endcase
        end
        return pack_ray(p[0], p[1], p[2], d[0], d[1], d[2]);
    endfunction

    task automatic send_ray(input logic [IN_DATA_W-1:0] ray);
        while (!no_idle && $urandom_range(99) < 24) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= ray;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
    endtask

    task automatic load_box(input logic [47:0] r0, r1, r2, input logic [63:0] oxy,
                            input logic [31:0] oz, input logic [63:0] hxy,
                            input logic [31:0] hz);
        drain();
        write_reg(REG_XFORM0, {16'hFFFF, r0});
        write_reg(REG_XFORM1, r1);
        write_reg(REG_XFORM2, r2);
        write_reg(REG_OFF_XY, oxy);
        write_reg(REG_OFF_Z, {32'hDEAD_BEEF, oz});
        write_reg(REG_HALF_XY, hxy);
        write_reg(REG_HALF_Z, hz);
        write_reg(REG_UNUSED, {$urandom(), $urandom()});
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] coef_rand();
        case ($urandom_range(3))
            0: return 16'h4000;
            1: return 16'hC000;
            2: return 16'h0000;
            default: return 16'($urandom());
        endcase
    endfunction

    initial begin
        logic [15:0] cf [9];
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rays against the reset unit box
        send_ray(pack_ray(0, 0, 0, 0, 0, 0));
        send_ray(pack_ray(0, 0, 0, 32'h0001_0000, 0, 0));
        send_ray(pack_ray(32'hFFFB_0000, 0, 0, 32'h0001_0000, 0, 0));
        send_ray(pack_ray(32'h0005_0000, 0, 0, 32'h0001_0000, 0, 0));
        send_ray(pack_ray(32'hFFFB_0000, 32'hFFFB_0000, 32'hFFFB_0000,
                          32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
        send_ray(pack_ray(0, 0, 0, 1, 1, 1));
        send_ray(pack_ray(0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_ray(pack_ray(0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
        send_ray(pack_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_ray(pack_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_ray(pack_ray(32'h8000_0000, 0, 0, 1, 0, 0));
        send_ray(pack_ray(32'h0000_8000, 32'h0000_8000, 32'h0000_8000,
                          32'hFFFF_0000, 0, 0));
        send_ray(pack_ray(32'h0000_8000, 0, 0, 32'h0000_0100, 32'hFFFF_FF00, 0));
        send_ray(pack_ray(32'h0003_0000, 0, 0, 32'h0001_0000, 32'h0000_0001, 0));
        send_ray(pack_ray(0, 32'h0002_0000, 0, 0, 32'hFFFE_0000, 0));
        send_ray(pack_ray(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 32'h0000_0001));
        send_ray(pack_ray(32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                          32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000));

        for (int ph = 0; ph < 8; ph++) begin
            for (int j = 0; j < 9; j++) cf[j] = coef_rand();
            case (ph)
                0: load_box(XFORM0_RST, XFORM1_RST, XFORM2_RST, '0, '0,
                            {32'h0002_0000, 32'h0003_0000}, 32'h0001_8000);
                1: load_box({3{16'h7FFF}}, {3{16'h8000}}, {16'h7FFF, 16'h8000, 16'h7FFF},
                            64'h7FFF_FFFF_8000_0000, 32'h7FFF_FFFF,
                            64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
                2: load_box('0, '0, '0, 64'h8000_0000_7FFF_FFFF, 32'h8000_0000, '0, '0);
                3: load_box({16'h0000, 16'h4000, 16'h0000}, {16'h0000, 16'h0000, 16'h4000},
                            {16'h0000, 16'h0000, 16'hC000},
                            {32'h0000_8000, 32'hFFFF_8000}, 32'h0001_0000,
                            {32'h0000_8000, 32'h0004_0000}, 32'h0002_0000);
                default: load_box({cf[2], cf[1], cf[0]}, {cf[5], cf[4], cf[3]},
                                  {cf[8], cf[7], cf[6]},
                                  {q_rand(3 << 16), q_rand(3 << 16)}, q_rand(3 << 16),
                                  {32'($urandom_range(5 << 16)), 32'($urandom_range(5 << 16))},
                                  32'($urandom_range(5 << 16)));
            endcase
            no_idle = (ph == 4);
            if (ph == 5) stall_tag++;
            for (int i = 0; i < 180; i++) send_ray(random_ray());
        end
        no_idle = 1'b0;

        drain();
        $display("%0d rays checked over 8 box settings, %0d hits and %0d misses",
                 rays, hits, rays - hits);
        $display("coverage included saturating transforms, zero and extreme directions, stalls");
        if (fail_cnt == 0) begin
            $display("ray_box_slab_intersect_core_test OK");
        end else begin
            $display("ray_box_slab_intersect_core_test NOT OK");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/rbsi_pkg.sv
hdl/ray_box_slab_intersect_core.sv
bench/ray_box_slab_intersect_checker.sv
bench/ray_box_slab_intersect_core_test.sv
